// ===== src/hgbs_pkg.sv =====
// ----------------------------------------------------------------------------
// hgbs_pkg
// Shared types and constants of the hit grid binning sorter.
// ----------------------------------------------------------------------------
`default_nettype none
package hgbs_pkg;

   // default sizes
   localparam int GRID_ROWS_DEF = 50;
   localparam int GRID_COLS_DEF = 50;
   localparam int SENSORS_DEF   = 48;
   localparam int MAX_HITS_DEF  = 64;

   // field widths
   localparam int COORD_W = 16;
   localparam int CELL_W  = 8;
   localparam int KEY_W   = 16;
   localparam int SENS_W  = 6;
   localparam int SLOT_W  = 16;
   localparam int CNT_W   = 7;
   localparam int OUTC_W  = 6;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W      = 3;

   // configuration register indexes
   localparam logic [1:0] CSR_ORIGIN_OFFSET = 2'd0;
   localparam logic [1:0] CSR_ROW_SCALE     = 2'd1;
   localparam logic [1:0] CSR_COL_SCALE     = 2'd2;

   localparam logic [14:0] ORIGIN_RESET = 15'd10240;
   localparam logic [15:0] SCALE_RESET  = 16'd40960;

   // one classified beat passed from front to back
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [CELL_W-1:0]  row;
      logic [CELL_W-1:0]  col;
      logic [KEY_W-1:0]   key;
      logic               has_hit;
      logic               last;
   } qentry_type;

endpackage
`default_nettype wire

// ===== src/hgbs_queue.sv =====
// ----------------------------------------------------------------------------
// hgbs_queue
// Small fifo between the binning front and the sorting back.
// ----------------------------------------------------------------------------
`default_nettype none
module hgbs_queue (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push,
   input  hgbs_pkg::qentry_type      push_data,
   input  wire                       pop,
   output hgbs_pkg::qentry_type      head,
   output logic                      not_empty,
   output logic [hgbs_pkg::QCNT_W-1:0] count
);
   localparam int AW = $clog2(hgbs_pkg::QUEUE_DEPTH);

   hgbs_pkg::qentry_type mem_ff [hgbs_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [hgbs_pkg::QCNT_W-1:0] cnt_ff, cnt_in;
   logic do_pop;

   assign do_pop    = pop && (cnt_ff != '0);
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ff];
   assign count     = cnt_ff;

   // pointer and fill bookkeeping
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{(hgbs_pkg::QCNT_W-1){1'b0}}, push}
                      - {{(hgbs_pkg::QCNT_W-1){1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== src/hgbs_front.sv =====
// ----------------------------------------------------------------------------
// hgbs_front
// Takes hit beats, holds the configuration and works out each hit's cell.
// ----------------------------------------------------------------------------
`default_nettype none
module hgbs_front #(
   parameter int GRID_ROWS = hgbs_pkg::GRID_ROWS_DEF,
   parameter int GRID_COLS = hgbs_pkg::GRID_COLS_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire  [47:0]                req_tdata,
   input  wire                        req_tuser,
   input  wire                        req_tlast,
   input  wire                        csr_we,
   input  wire  [1:0]                 csr_index,
   input  wire  [15:0]                csr_wdata,
   input  wire  [hgbs_pkg::QCNT_W-1:0] q_count,
   output logic                       q_push,
   output hgbs_pkg::qentry_type       q_data
);
   localparam logic [8:0] ROW_MAX = 9'(GRID_ROWS - 1);
   localparam logic [8:0] COL_MAX = 9'(GRID_COLS - 1);

   logic [14:0] origin_ff;
   logic [15:0] row_scale_ff, col_scale_ff;

   logic        s1_valid_ff, s1_valid_in;
   logic [15:0] s1_x_ff, s1_y_ff, s1_z_ff;
   logic        s1_has_ff, s1_last_ff;
   logic        s1_rneg_ff, s1_cneg_ff;
   logic [8:0]  s1_rcell_ff, s1_ccell_ff;

   logic        accept;
   logic signed [17:0] vx, vy;
   logic [32:0] px, py;
   logic [7:0]  row, col;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff    <= hgbs_pkg::ORIGIN_RESET;
         row_scale_ff <= hgbs_pkg::SCALE_RESET;
         col_scale_ff <= hgbs_pkg::SCALE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            hgbs_pkg::CSR_ORIGIN_OFFSET: origin_ff    <= csr_wdata[14:0];
            hgbs_pkg::CSR_ROW_SCALE:     row_scale_ff <= csr_wdata;
            hgbs_pkg::CSR_COL_SCALE:     col_scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // room for the beat in flight plus this one
   assign req_tready = ({1'b0, q_count} + {{hgbs_pkg::QCNT_W{1'b0}}, s1_valid_ff})
                       < (hgbs_pkg::QCNT_W+1)'(hgbs_pkg::QUEUE_DEPTH);
   assign accept = req_tvalid && req_tready;

   // offset and scale, integer part of the q9.24 product
   always_comb begin
      vx = 18'(signed'(req_tdata[15:0])) + signed'({3'b000, origin_ff});
      vy = 18'(signed'(req_tdata[31:16])) + signed'({3'b000, origin_ff});
      px = 33'(vx[16:0]) * 33'(row_scale_ff);
      py = 33'(vy[16:0]) * 33'(col_scale_ff);
      s1_valid_in = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_x_ff     <= req_tdata[15:0];
         s1_y_ff     <= req_tdata[31:16];
         s1_z_ff     <= req_tdata[47:32];
         s1_has_ff   <= req_tuser;
         s1_last_ff  <= req_tlast;
         s1_rneg_ff  <= vx[17];
         s1_cneg_ff  <= vy[17];
         s1_rcell_ff <= px[32:24];
         s1_ccell_ff <= py[32:24];
      end
   end

   // clamp to the grid and form the sort key
   always_comb begin
      row = s1_rneg_ff ? 8'd0 : (s1_rcell_ff > ROW_MAX ? ROW_MAX[7:0] : s1_rcell_ff[7:0]);
      col = s1_cneg_ff ? 8'd0 : (s1_ccell_ff > COL_MAX ? COL_MAX[7:0] : s1_ccell_ff[7:0]);
      q_data.x       = s1_x_ff;
      q_data.y       = s1_y_ff;
      q_data.z       = s1_z_ff;
      q_data.row     = row;
      q_data.col     = col;
      q_data.key     = 16'(16'(row) * 16'(GRID_COLS)) + 16'(col);
      q_data.has_hit = s1_has_ff;
      q_data.last    = s1_last_ff;
      q_push         = s1_valid_ff;
   end

endmodule
`default_nettype wire

// ===== src/hgbs_back.sv =====
// ----------------------------------------------------------------------------
// hgbs_back
// Buffers the hits of a sensor and sends them out sorted by cell key.
// ----------------------------------------------------------------------------
`default_nettype none
module hgbs_back #(
   parameter int SENSORS  = hgbs_pkg::SENSORS_DEF,
   parameter int MAX_HITS = hgbs_pkg::MAX_HITS_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  hgbs_pkg::qentry_type  q_head,
   input  wire                   q_not_empty,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [111:0]          rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);
   localparam int IDX_W  = $clog2(MAX_HITS);
   localparam int HELD_W = $clog2(MAX_HITS + 1);
   localparam logic [HELD_W-1:0] HELD_MAX = HELD_W'(MAX_HITS);
   localparam logic [5:0] SENS_LAST = 6'(SENSORS - 1);

   typedef enum logic [4:0] {
      S_IDLE      = 5'b00001,
      S_SCAN_RD   = 5'b00010,
      S_SCAN_CHK  = 5'b00100,
      S_EMIT_RD   = 5'b01000,
      S_EMIT_CHK  = 5'b10000
   } state_type;

   localparam int ENT_W = 3*hgbs_pkg::COORD_W + 2*hgbs_pkg::CELL_W + hgbs_pkg::KEY_W;

   logic [ENT_W-1:0] mem [MAX_HITS];
   logic [ENT_W-1:0] rd_ff;

   state_type state_ff, state_in;
   logic [HELD_W-1:0] held_ff, held_in, emitted_ff, emitted_in, base_ff, base_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              ovf_ff, ovf_in;
   logic [5:0]        sens_ff, sens_in;
   logic [15:0]       slot_ff, slot_in;
   logic              have_last_ff, have_last_in, found_ff, found_in;
   logic [15:0]       last_key_ff, last_key_in, best_ff, best_in;
   logic [6:0]        cnt_ff, cnt_in;
   logic              ovalid_ff, ovalid_in;
   logic              load, wr_en, at_end, elig, match, finish;
   logic [15:0]       rd_x, rd_y, rd_z, rd_key;
   logic [7:0]        rd_row, rd_col;

   assign {rd_x, rd_y, rd_z, rd_row, rd_col, rd_key} = rd_ff;
   assign at_end = (HELD_W'(idx_ff) == held_ff - 1'b1);
   assign elig   = !have_last_ff || (rd_key > last_key_ff);
   assign match  = (rd_key == best_ff);
   assign wr_en  = (state_ff == S_IDLE) && q_not_empty && q_head.has_hit
                   && (held_ff < HELD_MAX);

   // hit store, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[held_ff[IDX_W-1:0]] <= {q_head.x, q_head.y, q_head.z,
                                     q_head.row, q_head.col, q_head.key};
      end
      rd_ff <= mem[idx_ff];
   end

   // sequencer: gather, then per cell group scan for the next key and emit
   always_comb begin
      state_in     = state_ff;
      held_in      = held_ff;
      emitted_in   = emitted_ff;
      base_in      = base_ff;
      idx_in       = idx_ff;
      ovf_in       = ovf_ff;
      sens_in      = sens_ff;
      slot_in      = slot_ff;
      have_last_in = have_last_ff;
      found_in     = found_ff;
      last_key_in  = last_key_ff;
      best_in      = best_ff;
      cnt_in       = cnt_ff;
      q_pop        = 1'b0;
      load         = 1'b0;
      finish       = 1'b0;
      ovalid_in    = ovalid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (q_not_empty) begin
               q_pop = 1'b1;
               if (q_head.has_hit) begin
                  if (held_ff < HELD_MAX) held_in = held_ff + 1'b1;
                  else                    ovf_in  = 1'b1;
               end
               if (q_head.last) begin
                  if (held_in == '0) begin
                     sens_in = (sens_ff == SENS_LAST) ? 6'd0 : sens_ff + 6'd1;
                     ovf_in  = 1'b0;
                  end else begin
                     state_in     = S_SCAN_RD;
                     idx_in       = '0;
                     emitted_in   = '0;
                     have_last_in = 1'b0;
                     found_in     = 1'b0;
                  end
               end
            end
         end
         S_SCAN_RD: state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            if (elig && (!found_ff || rd_key < best_ff)) begin
               best_in  = rd_key;
               cnt_in   = 7'd1;
               found_in = 1'b1;
            end else if (elig && match) begin
               cnt_in = cnt_ff + 7'd1;
            end
            if (at_end) begin
               state_in = S_EMIT_RD;
               idx_in   = '0;
               base_in  = emitted_ff;
            end else begin
               state_in = S_SCAN_RD;
               idx_in   = idx_ff + 1'b1;
            end
         end
         S_EMIT_RD: state_in = S_EMIT_CHK;
         S_EMIT_CHK: begin
            if (!match || !ovalid_ff || rsp_tready) begin
               if (match) begin
                  load       = 1'b1;
                  ovalid_in  = 1'b1;
                  emitted_in = emitted_ff + 1'b1;
               end
               if (at_end) begin
                  if (emitted_in == held_ff) begin
                     finish     = 1'b1;
                     state_in   = S_IDLE;
                     sens_in    = (sens_ff == SENS_LAST) ? 6'd0 : sens_ff + 6'd1;
                     slot_in    = slot_ff + 16'(held_ff);
                     held_in    = '0;
                     emitted_in = '0;
                     ovf_in     = 1'b0;
                     idx_in     = '0;
                  end else begin
                     state_in     = S_SCAN_RD;
                     idx_in       = '0;
                     have_last_in = 1'b1;
                     last_key_in  = best_ff;
                     found_in     = 1'b0;
                  end
               end else begin
                  state_in = S_EMIT_RD;
                  idx_in   = idx_ff + 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         emitted_ff   <= '0;
         idx_ff       <= '0;
         ovf_ff       <= 1'b0;
         sens_ff      <= '0;
         slot_ff      <= '0;
         have_last_ff <= 1'b0;
         found_ff     <= 1'b0;
         ovalid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         emitted_ff   <= emitted_in;
         idx_ff       <= idx_in;
         ovf_ff       <= ovf_in;
         sens_ff      <= sens_in;
         slot_ff      <= slot_in;
         have_last_ff <= have_last_in;
         found_ff     <= found_in;
         ovalid_ff    <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      last_key_ff <= last_key_in;
      best_ff     <= best_in;
      cnt_ff      <= cnt_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_tdata <= {7'd0, cnt_ff,
                       slot_ff + 16'(base_ff),
                       slot_ff + 16'(emitted_ff),
                       rd_col[5:0], rd_row[5:0], sens_ff,
                       rd_z, rd_y, rd_x};
         rsp_tuser <= ovf_ff;
         rsp_tlast <= (emitted_ff == held_ff - 1'b1);
      end
   end
   assign rsp_tvalid = ovalid_ff;

   // checks
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      emitted_ff <= held_ff)
      else $error("more hits sent than held");
   a_group_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT_CHK) |-> (cnt_ff != 7'd0 && found_ff))
      else $error("emit pass without a cell group");
   a_finish_clear: assert property (@(posedge clock) disable iff (reset)
      finish |=> (held_ff == '0 && state_ff == S_IDLE))
      else $error("sensor not cleared after last result");
   a_last_emit: assert property (@(posedge clock) disable iff (reset)
      (load && emitted_ff == held_ff - 1'b1) |-> (held_ff != '0 && state_ff == S_EMIT_CHK))
      else $error("final result outside the emit pass");

endmodule
`default_nettype wire

// ===== src/hit_grid_binning_sorter_top.sv =====
// ----------------------------------------------------------------------------
// hit_grid_binning_sorter_top
// Bins detector hits to a 2d grid and sends each sensor's hits sorted by cell.
// ----------------------------------------------------------------------------
// Each hit beat is binned in the front (offset, scale multiply, clamp, key)
// at one beat per cycle while the queue has room, and queued. The back stores
// up to MAX_HITS hits of a sensor, one per cycle while it is idle. On the
// sensor's last beat it sorts by scanning its hit store: for each distinct
// cell it makes one pass to find the next key and one pass to send that cell's
// hits, each pass reading every stored hit in turn through the single read
// port of the hit store, and the next sensor's beats wait in the queue until
// the sensor is done. No clearing pass is needed after reset.
`default_nettype none
module hit_grid_binning_sorter_top #(
   parameter int GRID_ROWS = hgbs_pkg::GRID_ROWS_DEF,
   parameter int GRID_COLS = hgbs_pkg::GRID_COLS_DEF,
   parameter int SENSORS   = hgbs_pkg::SENSORS_DEF,
   parameter int MAX_HITS  = hgbs_pkg::MAX_HITS_DEF
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [47:0]  req_tdata,   // coord_x, coord_y, plane_z
   input  wire          req_tuser,   // has_hit
   input  wire          req_tlast,   // sensor_last
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [111:0] rsp_tdata,   // out_x, out_y, out_z, sensor_number, cell_row,
                                     // cell_col, global_slot, cell_start, cell_count
   output logic         rsp_tuser,   // overflowed
   output logic         rsp_tlast,   // last_of_sensor
   input  wire          csr_we,
   input  wire  [1:0]   csr_index,
   input  wire  [15:0]  csr_wdata
);
   hgbs_pkg::qentry_type q_in, q_head;
   logic q_push, q_pop, q_not_empty;
   logic [hgbs_pkg::QCNT_W-1:0] q_count;

   // binning front
   hgbs_front #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .q_count(q_count), .q_push(q_push), .q_data(q_in)
   );

   // queue between the two halves
   hgbs_queue u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_data(q_in), .pop(q_pop),
      .head(q_head), .not_empty(q_not_empty), .count(q_count)
   );

   // sorting back
   hgbs_back #(.SENSORS(SENSORS), .MAX_HITS(MAX_HITS)) u_back (
      .clock(clock), .reset(reset),
      .q_head(q_head), .q_not_empty(q_not_empty), .q_pop(q_pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the hit grid binning sorter: directed table, then
// random sensors over several grid settings, each result compared to a model.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;

   localparam int ROWS     = hgbs_pkg::GRID_ROWS_DEF;
   localparam int COLS     = hgbs_pkg::GRID_COLS_DEF;
   localparam int NSENS    = hgbs_pkg::SENSORS_DEF;
   localparam int HIT_CAP  = hgbs_pkg::MAX_HITS_DEF;
   localparam int LIMIT    = 600000;
   localparam int NO_CHECK = -1;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // result beat as laid out on rsp_tdata, msb first
   typedef struct packed {
      logic [6:0]  pad;
      logic [6:0]  cell_count;
      logic [15:0] cell_start;
      logic [15:0] global_slot;
      logic [5:0]  cell_col;
      logic [5:0]  cell_row;
      logic [5:0]  sensor_number;
      logic [15:0] out_z;
      logic [15:0] out_y;
      logic [15:0] out_x;
   } sorted_hit_type;

   typedef struct {
      sorted_hit_type data;
      logic           overflowed;
      logic           last_of_sensor;
   } sorted_beat_type;

   typedef struct {
      logic [15:0] x, y, z;
      logic [7:0]  row, col;
   } held_hit_type;

   // directed row: typed cell where it is obvious, else NO_CHECK
   typedef struct {
      logic [15:0] x, y, z;
      logic        has_hit, last;
      int          row_exp, col_exp;
   } dir_row_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [47:0]  req_tdata = '0;
   logic         req_tuser = 0;
   logic         req_tlast = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [111:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we = 0;
   logic [1:0]   csr_index = '0;
   logic [15:0]  csr_wdata = '0;

   hit_grid_binning_sorter_top dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // model state
   logic [14:0]     origin_reg;
   logic [15:0]     row_scale_reg, col_scale_reg;
   held_hit_type    sensor_hits[$];
   logic            drop_seen;
   int              sensor_ctr;
   logic [15:0]     slot_ctr;
   sorted_beat_type pending_hits[$];

   int  errors = 0;
   int  cycles = 0;
   int  hits_sent = 0, sensors_done = 0, beats_seen = 0;
   bit  calm = 0;

   // cell of one coordinate: offset, scale, truncate, clamp
   function automatic logic [7:0] cell_of(logic [15:0] c, logic [15:0] scale, int lim);
      logic signed [17:0] v;
      logic [47:0]        prod;
      v = $signed(c) + $signed({3'b0, origin_reg});
      if (v < 0) return 0;
      prod = 48'(v) * scale;
      prod = prod >> 24;
      if (prod > lim - 1) return 8'(lim - 1);
      return prod[7:0];
   endfunction

   function automatic int key_of(held_hit_type h);
      return h.row * COLS + h.col;
   endfunction

   // accepted input beat: store hit, on last sort and queue the results
   task automatic bin_and_sort(logic [15:0] x, y, z, logic has_hit, last);
      held_hit_type    h, order[$];
      sorted_beat_type b;
      int              i, j, e, n;
      if (has_hit) begin
         hits_sent++;
         if (sensor_hits.size() < HIT_CAP) begin
            h.x = x; h.y = y; h.z = z;
            h.row = cell_of(x, row_scale_reg, ROWS);
            h.col = cell_of(y, col_scale_reg, COLS);
            sensor_hits.push_back(h);
         end else
            drop_seen = 1;
      end
      if (!last) return;
      // stable insertion
      foreach (sensor_hits[k]) begin
         j = order.size();
         while (j > 0 && key_of(order[j-1]) > key_of(sensor_hits[k])) j--;
         order.insert(j, sensor_hits[k]);
      end
      n = order.size();
      i = 0;
      while (i < n) begin
         e = i;
         while (e < n && key_of(order[e]) == key_of(order[i])) e++;
         for (j = i; j < e; j++) begin
            b.data = '0;
            b.data.out_x = order[j].x;
            b.data.out_y = order[j].y;
            b.data.out_z = order[j].z;
            b.data.sensor_number = 6'(sensor_ctr);
            b.data.cell_row = order[j].row[5:0];
            b.data.cell_col = order[j].col[5:0];
            b.data.global_slot = slot_ctr + 16'(j);
            b.data.cell_start = slot_ctr + 16'(i);
            b.data.cell_count = 7'(e - i);
            b.overflowed = drop_seen;
            b.last_of_sensor = (j == n - 1);
            pending_hits.push_back(b);
         end
         i = e;
      end
      slot_ctr += 16'(n);
      sensor_ctr = (sensor_ctr + 1 >= NSENS) ? 0 : sensor_ctr + 1;
      sensor_hits.delete();
      drop_seen = 0;
      sensors_done++;
   endtask

   // drive one beat, with random idle cycles ahead of it unless calm is set
   task automatic send_hit(logic [15:0] x, y, z, logic has_hit, last);
      if (!calm) begin
         while ($urandom_range(99) < 19) begin
            req_tvalid <= 0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1;
      req_tdata  <= {z, y, x};
      req_tuser  <= has_hit;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      bin_and_sort(x, y, z, has_hit, last);
   endtask

   // one register write, then csr_we low again before the task returns
   task automatic csr_write(logic [1:0] idx, logic [15:0] val);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         hgbs_pkg::CSR_ORIGIN_OFFSET: origin_reg = val[14:0];
         hgbs_pkg::CSR_ROW_SCALE:     row_scale_reg = val;
         hgbs_pkg::CSR_COL_SCALE:     col_scale_reg = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 0;
      wait (pending_hits.size() == 0);
      repeat (300) @(posedge clock);
   endtask

   // random sensor: mostly well formed, small, some noise markers
   task automatic random_sensor(int max_n, bit narrow);
      int          n;
      logic [15:0] x, y;
      n = $urandom_range(max_n);
      if (n == 0) begin
         send_hit(16'($urandom), 16'($urandom), 16'($urandom), 0, 1);
         return;
      end
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(9) == 0)
            send_hit(16'($urandom), 16'($urandom), 16'($urandom), 0, 0);
         x = narrow ? 16'($urandom_range(1200)) - 16'd600 : 16'($urandom);
         y = narrow ? 16'($urandom_range(1200)) - 16'd600 : 16'($urandom);
         send_hit(x, y, 16'($urandom), 1, k == n - 1);
      end
   endtask

   dir_row_type dir_rows [13] = '{
      '{16'h0000, 16'h0000, 16'h1234, 1, 0, 25, 25},
      '{16'h8000, 16'h7FFF, 16'h8000, 1, 0, 0, 49},
      '{16'h7FFF, 16'h8000, 16'h7FFF, 1, 0, 49, 0},
      '{16'hD800, 16'hD7FF, 16'hFFFF, 1, 0, 0, 0},
      '{16'h0000, 16'h0000, 16'h0001, 1, 0, 25, 25},
      '{16'h0000, 16'h0000, 16'h0002, 0, 0, NO_CHECK, NO_CHECK},
      '{16'h0100, 16'hFF00, 16'h0003, 1, 1, NO_CHECK, NO_CHECK},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 1, NO_CHECK, NO_CHECK},
      '{16'h1000, 16'h2000, 16'h5555, 1, 1, NO_CHECK, NO_CHECK},
      '{16'hAAAA, 16'h5555, 16'hAAAA, 1, 0, NO_CHECK, NO_CHECK},
      '{16'h5555, 16'hAAAA, 16'h5555, 1, 0, NO_CHECK, NO_CHECK},
      '{16'h0000, 16'h0000, 16'h0000, 0, 1, NO_CHECK, NO_CHECK},
      '{16'h0000, 16'h0000, 16'h0000, 0, 1, NO_CHECK, NO_CHECK}
   };

   // result checker and receiver stalls
   always @(posedge clock) begin
      sorted_beat_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            beats_seen++;
            if (pending_hits.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected beat %h", rsp_tdata);
            end else begin
               want = pending_hits.pop_front();
               if (rsp_tdata !== want.data || rsp_tuser !== want.overflowed ||
                   rsp_tlast !== want.last_of_sensor) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp %h ovf %b last %b, got %h ovf %b last %b",
                              want.data, want.overflowed, want.last_of_sensor,
                              rsp_tdata, rsp_tuser, rsp_tlast);
               end
            end
         end
         rsp_tready <= calm || ($urandom_range(99) >= 19);
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      origin_reg = hgbs_pkg::ORIGIN_RESET;
      row_scale_reg = hgbs_pkg::SCALE_RESET;
      col_scale_reg = hgbs_pkg::SCALE_RESET;
      drop_seen = 0;
      sensor_ctr = 0;
      slot_ctr = '0;
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed table at reset settings
      foreach (dir_rows[r]) begin
         if (dir_rows[r].row_exp != NO_CHECK &&
             (cell_of(dir_rows[r].x, row_scale_reg, ROWS) != dir_rows[r].row_exp ||
              cell_of(dir_rows[r].y, col_scale_reg, COLS) != dir_rows[r].col_exp)) begin
            errors++;
            $display("row %0d: cell differs from table", r);
         end
         send_hit(dir_rows[r].x, dir_rows[r].y, dir_rows[r].z,
                  dir_rows[r].has_hit, dir_rows[r].last);
      end
      // too many hits in one sensor
      for (int k = 0; k < HIT_CAP + 3; k++)
         send_hit(16'($urandom_range(3000)), 16'($urandom_range(3000)),
                  16'($urandom), 1, k == HIT_CAP + 2);
      drain();

      // settings: extremes, upper bits and unused index, reset values, then random
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               csr_write(hgbs_pkg::CSR_ORIGIN_OFFSET, 16'h0000);
               csr_write(hgbs_pkg::CSR_ROW_SCALE, 16'hFFFF);
               csr_write(hgbs_pkg::CSR_COL_SCALE, 16'hFFFF);
            end
            1: begin
               csr_write(hgbs_pkg::CSR_ORIGIN_OFFSET, 16'hFFFF);
               csr_write(hgbs_pkg::CSR_ROW_SCALE, 16'h0000);
               csr_write(hgbs_pkg::CSR_COL_SCALE, 16'h0100);
               csr_write(CSR_UNUSED, 16'h1234);
            end
            2: begin
               csr_write(hgbs_pkg::CSR_ORIGIN_OFFSET, 16'(hgbs_pkg::ORIGIN_RESET));
               csr_write(hgbs_pkg::CSR_ROW_SCALE, hgbs_pkg::SCALE_RESET);
               csr_write(hgbs_pkg::CSR_COL_SCALE, hgbs_pkg::SCALE_RESET);
            end
            default: begin
               csr_write(hgbs_pkg::CSR_ORIGIN_OFFSET, 16'($urandom));
               csr_write(hgbs_pkg::CSR_ROW_SCALE, 16'($urandom));
               csr_write(hgbs_pkg::CSR_COL_SCALE, 16'($urandom));
            end
         endcase
         for (int s = 0; s < 11; s++) begin
            calm = (ph == 2 && s >= 2 && s < 10);
            random_sensor(8, $urandom_range(1));
         end
         calm = 0;
         drain();
      end

      $display("%0d hits in %0d sensors, %0d sorted beats, 5 grid settings",
               hits_sent, sensors_done, beats_seen);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
`default_nettype wire
